// File: design/dtd_pkg.sv
// shared types and constants for the day/time duration alu
`timescale 1ns / 1ps

package dtd_pkg;

  localparam int DAY_BITS_DEF = 16;

  localparam int FUNC_W  = 4;
  localparam int DAY_W   = 16;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int DELTA_W = 31;

  localparam int SEC_PER_MIN  = 60;
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_DAY  = 86400;

  // seconds of day of one operand, sums of two, remainder of the day split
  localparam int SOD_W  = 17;
  localparam int SUM_W  = 19;
  localparam int DR_W   = 18;
  localparam int DQ_W   = 15;
  localparam int MREM_W = 12;

  // reciprocal multipliers for the constant divisions
  localparam int DAY_RECIP     = 49710;
  localparam int DAY_RECIP_SH  = 32;
  localparam int PROD_W        = DELTA_W + 16;
  localparam int HOUR_RECIP    = 37283;
  localparam int HOUR_RECIP_SH = 27;
  localparam int HPROD_W       = SOD_W + 16;
  localparam int MIN_RECIP     = 4370;
  localparam int MIN_RECIP_SH  = 18;
  localparam int MPROD_W       = MREM_W + 13;

  localparam int NSTAGE   = 8;
  localparam int FRONT_ST = 3;
  localparam int BACK_ST  = NSTAGE - FRONT_ST;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_ADD_SECS = 4'd2,
    FN_SUB_SECS = 4'd3,
    FN_EQ       = 4'd4,
    FN_NE       = 4'd5,
    FN_GT       = 4'd6,
    FN_GE       = 4'd7,
    FN_LT       = 4'd8,
    FN_LE       = 4'd9
  } func_t;

  typedef struct packed {
    logic [DAY_W-1:0]  res_day;
    logic [HOUR_W-1:0] res_hour;
    logic [MIN_W-1:0]  res_minute;
    logic [SEC_W-1:0]  res_second;
    logic              compare_true;
    logic              day_overflow;
  } dtd_res_t;

  function automatic int day_calc_w(int day_bits);
    return ((day_bits > DAY_W) ? day_bits : DAY_W) + 3;
  endfunction

endpackage

// File: design/dtd_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface dtd_req_if;
  import dtd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [DAY_W-1:0]   a_day;
  logic [HOUR_W-1:0]         a_hour;
  logic [MIN_W-1:0]          a_minute;
  logic [SEC_W-1:0]          a_second;
  logic signed [DAY_W-1:0]   b_day;
  logic [HOUR_W-1:0]         b_hour;
  logic [MIN_W-1:0]          b_minute;
  logic [SEC_W-1:0]          b_second;
  logic [DELTA_W-1:0]        seconds_delta;

  modport source (
    output valid, func, a_day, a_hour, a_minute, a_second,
           b_day, b_hour, b_minute, b_second, seconds_delta,
    input  ready
  );
  modport sink (
    input  valid, func, a_day, a_hour, a_minute, a_second,
           b_day, b_hour, b_minute, b_second, seconds_delta,
    output ready
  );
endinterface

interface dtd_rsp_if;
  import dtd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DAY_W-1:0]   res_day;
  logic [HOUR_W-1:0]         res_hour;
  logic [MIN_W-1:0]          res_minute;
  logic [SEC_W-1:0]          res_second;
  logic                      compare_true;
  logic                      day_overflow;

  modport source (
    output valid, res_day, res_hour, res_minute, res_second,
           compare_true, day_overflow,
    input  ready
  );
  modport sink (
    input  valid, res_day, res_hour, res_minute, res_second,
           compare_true, day_overflow,
    output ready
  );
endinterface

// File: design/dtd_ctrl.sv
// valid bits and stage enables of the pipeline
`timescale 1ns / 1ps

module dtd_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output logic [dtd_pkg::NSTAGE-1:0] en
);
  import dtd_pkg::*;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] vld_next;
  logic [NSTAGE-1:0] shifted;

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rsp_ready;
    for (int i = NSTAGE - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign shifted = {vld[NSTAGE-2:0], req_valid};

  always_comb begin
    for (int i = 0; i < NSTAGE; i++) begin
      vld_next[i] = en[i] ? shifted[i] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign req_ready = en[0];
  assign rsp_valid = vld[NSTAGE-1];

endmodule

// File: design/dtd_front.sv
// operand conversion, compare, seconds split and add/subtract stages
`timescale 1ns / 1ps

module dtd_front #(
  parameter int DAY_BITS = dtd_pkg::DAY_BITS_DEF,
  parameter int DW       = dtd_pkg::day_calc_w(dtd_pkg::DAY_BITS_DEF)
) (
  input  logic                              clk,
  input  logic [dtd_pkg::FRONT_ST-1:0]      en,
  dtd_req_if.sink                           req,
  output logic signed [dtd_pkg::SUM_W-1:0]  sum,
  output logic signed [DW-1:0]              day,
  output logic                              arith,
  output logic                              cmp
);
  import dtd_pkg::*;

  logic [DW-1:0]        ad_raw, bd_raw;
  logic signed [DW-1:0] ad_x, bd_x;
  logic [SOD_W-1:0]     sa_c, sb_c;
  logic                 eq_c, gt_c, cmp_c;

  // stage 1
  logic [FUNC_W-1:0]    s1_func;
  logic signed [DW-1:0] s1_ad, s1_bd;
  logic [SOD_W-1:0]     s1_sa, s1_sb;
  logic [DELTA_W-1:0]   s1_delta;
  logic [PROD_W-1:0]    s1_prod;
  logic                 s1_cmp;

  // stage 2
  logic [DQ_W-1:0]      dq0_c;
  logic [31:0]          dq_sec;
  logic [DR_W-1:0]      dr0_c;
  logic [FUNC_W-1:0]    s2_func;
  logic signed [DW-1:0] s2_ad, s2_bd;
  logic [SOD_W-1:0]     s2_sa, s2_sb;
  logic [DQ_W-1:0]      s2_dq0;
  logic [DR_W-1:0]      s2_dr0;
  logic                 s2_cmp;

  // stage 3
  logic [DQ_W-1:0]         dq_c;
  logic [SOD_W-1:0]        dr_c;
  logic signed [SUM_W-1:0] sum_c;
  logic signed [DW-1:0]    dadd_c;

  assign ad_raw = {{(DW-DAY_W){1'b0}}, req.a_day};
  assign bd_raw = {{(DW-DAY_W){1'b0}}, req.b_day};

  // day fields hold DAY_BITS-bit two's complement values
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      ad_x[i] = (i < DAY_BITS) ? ad_raw[i] : ad_raw[DAY_BITS-1];
      bd_x[i] = (i < DAY_BITS) ? bd_raw[i] : bd_raw[DAY_BITS-1];
    end
  end

  assign sa_c = SOD_W'(req.a_hour) * SOD_W'(SEC_PER_HOUR)
              + SOD_W'(req.a_minute) * SOD_W'(SEC_PER_MIN) + SOD_W'(req.a_second);
  assign sb_c = SOD_W'(req.b_hour) * SOD_W'(SEC_PER_HOUR)
              + SOD_W'(req.b_minute) * SOD_W'(SEC_PER_MIN) + SOD_W'(req.b_second);

  always_comb begin
    eq_c = (ad_x == bd_x) && (req.a_hour == req.b_hour)
        && (req.a_minute == req.b_minute) && (req.a_second == req.b_second);
    if (ad_x != bd_x) begin
      gt_c = ad_x > bd_x;
    end else if (req.a_hour != req.b_hour) begin
      gt_c = req.a_hour > req.b_hour;
    end else if (req.a_minute != req.b_minute) begin
      gt_c = req.a_minute > req.b_minute;
    end else begin
      gt_c = req.a_second > req.b_second;
    end
    case (req.func)
      FN_EQ:   cmp_c = eq_c;
      FN_NE:   cmp_c = !eq_c;
      FN_GT:   cmp_c = gt_c;
      FN_GE:   cmp_c = gt_c || eq_c;
      FN_LT:   cmp_c = !(gt_c || eq_c);
      FN_LE:   cmp_c = !gt_c;
      default: cmp_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_func  <= req.func;
      s1_ad    <= ad_x;
      s1_bd    <= bd_x;
      s1_sa    <= sa_c;
      s1_sb    <= sb_c;
      s1_delta <= req.seconds_delta;
      s1_prod  <= PROD_W'(req.seconds_delta) * PROD_W'(DAY_RECIP);
      s1_cmp   <= cmp_c;
    end
  end

  // quotient estimate is exact or one low; remainder fits below two days
  assign dq0_c  = s1_prod[DAY_RECIP_SH +: DQ_W];
  assign dq_sec = 32'(dq0_c) * 32'(SEC_PER_DAY);
  assign dr0_c  = s1_delta[DR_W-1:0] - dq_sec[DR_W-1:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_func <= s1_func;
      s2_ad   <= s1_ad;
      s2_bd   <= s1_bd;
      s2_sa   <= s1_sa;
      s2_sb   <= s1_sb;
      s2_dq0  <= dq0_c;
      s2_dr0  <= dr0_c;
      s2_cmp  <= s1_cmp;
    end
  end

  always_comb begin
    if (s2_dr0 >= DR_W'(SEC_PER_DAY)) begin
      dq_c = s2_dq0 + DQ_W'(1);
      dr_c = SOD_W'(s2_dr0 - DR_W'(SEC_PER_DAY));
    end else begin
      dq_c = s2_dq0;
      dr_c = SOD_W'(s2_dr0);
    end
    case (s2_func)
      FN_ADD: begin
        sum_c  = SUM_W'(s2_sa) + SUM_W'(s2_sb);
        dadd_c = s2_bd;
      end
      FN_SUB: begin
        sum_c  = SUM_W'(s2_sa) - SUM_W'(s2_sb);
        dadd_c = -s2_bd;
      end
      FN_ADD_SECS: begin
        sum_c  = SUM_W'(s2_sa) + SUM_W'(dr_c);
        dadd_c = DW'(dq_c);
      end
      FN_SUB_SECS: begin
        sum_c  = SUM_W'(s2_sa) - SUM_W'(dr_c);
        dadd_c = -DW'(dq_c);
      end
      default: begin
        sum_c  = '0;
        dadd_c = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum   <= sum_c;
      day   <= s2_ad + dadd_c;
      arith <= (s2_func == FN_ADD) || (s2_func == FN_SUB)
            || (s2_func == FN_ADD_SECS) || (s2_func == FN_SUB_SECS);
      cmp   <= s2_cmp;
    end
  end

endmodule

// File: design/dtd_back.sv
// day normalization and hour/minute/second split stages
`timescale 1ns / 1ps

module dtd_back #(
  parameter int DAY_BITS = dtd_pkg::DAY_BITS_DEF,
  parameter int DW       = dtd_pkg::day_calc_w(dtd_pkg::DAY_BITS_DEF)
) (
  input  logic                             clk,
  input  logic [dtd_pkg::BACK_ST-1:0]      en,
  input  logic signed [dtd_pkg::SUM_W-1:0] sum,
  input  logic signed [DW-1:0]             day,
  input  logic                             arith,
  input  logic                             cmp,
  output dtd_pkg::dtd_res_t                res
);
  import dtd_pkg::*;

  localparam logic [DAY_W-1:0] DAY_MASK =
    (DAY_BITS >= DAY_W) ? {DAY_W{1'b1}} : DAY_W'((64'd1 << DAY_BITS) - 64'd1);
  localparam logic signed [SUM_W-1:0] SPD = SUM_W'(SEC_PER_DAY);

  // stage 4
  logic signed [SUM_W-1:0] adj_c;
  logic signed [DW-1:0]    kd_c;
  logic signed [DW-1:0]    q_c;
  logic [DW-DAY_BITS:0]    q_top;
  logic                    ovf_c;
  logic [SOD_W-1:0]        s4_r;
  logic [DAY_W-1:0]        s4_day;
  logic                    s4_ovf, s4_arith, s4_cmp;

  // stage 5
  logic [HPROD_W-1:0]      hprod;
  logic [HOUR_W-1:0]       s5_hour;
  logic [SOD_W-1:0]        s5_r;
  logic [DAY_W-1:0]        s5_day;
  logic                    s5_ovf, s5_arith, s5_cmp;

  // stage 6
  logic [SOD_W-1:0]        hsec;
  logic [HOUR_W-1:0]       s6_hour;
  logic [MREM_W-1:0]       s6_mrem;
  logic [DAY_W-1:0]        s6_day;
  logic                    s6_ovf, s6_arith, s6_cmp;

  // stage 7
  logic [MPROD_W-1:0]      mprod;
  logic [HOUR_W-1:0]       s7_hour;
  logic [MIN_W-1:0]        s7_min;
  logic [MREM_W-1:0]       s7_mrem;
  logic [DAY_W-1:0]        s7_day;
  logic                    s7_ovf, s7_arith, s7_cmp;

  logic [MREM_W-1:0]       msec;

  // floor division of the second sum by one day
  always_comb begin
    if (sum < -SPD) begin
      adj_c = sum + (SPD <<< 1);
      kd_c  = DW'(-2);
    end else if (sum < 0) begin
      adj_c = sum + SPD;
      kd_c  = DW'(-1);
    end else if (sum >= (SPD <<< 1)) begin
      adj_c = sum - (SPD <<< 1);
      kd_c  = DW'(2);
    end else if (sum >= SPD) begin
      adj_c = sum - SPD;
      kd_c  = DW'(1);
    end else begin
      adj_c = sum;
      kd_c  = '0;
    end
    q_c   = day + kd_c;
    q_top = q_c[DW-1:DAY_BITS-1];
    ovf_c = arith && !((q_top == '0) || (q_top == '1));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_r     <= SOD_W'(adj_c);
      s4_day   <= q_c[DAY_W-1:0] & DAY_MASK;
      s4_ovf   <= ovf_c;
      s4_arith <= arith;
      s4_cmp   <= cmp;
    end
  end

  assign hprod = HPROD_W'(s4_r) * HPROD_W'(HOUR_RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s5_hour  <= hprod[HOUR_RECIP_SH +: HOUR_W];
      s5_r     <= s4_r;
      s5_day   <= s4_day;
      s5_ovf   <= s4_ovf;
      s5_arith <= s4_arith;
      s5_cmp   <= s4_cmp;
    end
  end

  assign hsec = SOD_W'(s5_hour) * SOD_W'(SEC_PER_HOUR);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s6_hour  <= s5_hour;
      s6_mrem  <= MREM_W'(s5_r - hsec);
      s6_day   <= s5_day;
      s6_ovf   <= s5_ovf;
      s6_arith <= s5_arith;
      s6_cmp   <= s5_cmp;
    end
  end

  assign mprod = MPROD_W'(s6_mrem) * MPROD_W'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s7_hour  <= s6_hour;
      s7_min   <= mprod[MIN_RECIP_SH +: MIN_W];
      s7_mrem  <= s6_mrem;
      s7_day   <= s6_day;
      s7_ovf   <= s6_ovf;
      s7_arith <= s6_arith;
      s7_cmp   <= s6_cmp;
    end
  end

  assign msec = MREM_W'(s7_min) * MREM_W'(SEC_PER_MIN);

  // output register; time fields stay zero for compares and unused codes
  always_ff @(posedge clk) begin
    if (en[4]) begin
      res.res_day      <= s7_arith ? s7_day : '0;
      res.res_hour     <= s7_arith ? s7_hour : '0;
      res.res_minute   <= s7_arith ? s7_min : '0;
      res.res_second   <= s7_arith ? SEC_W'(s7_mrem - msec) : '0;
      res.compare_true <= s7_cmp;
      res.day_overflow <= s7_ovf;
    end
  end

endmodule

// File: design/day_time_duration_alu.sv
// top level of the day/time duration alu
//
// Takes one request per cycle on req while req.ready is high: an operation code, two durations in
// days, hours, minutes and seconds, and a seconds count. Returns one result
// per request on rsp, in request order: a normalized duration with a day
// overflow flag for add and subtract, or a compare flag for the six compares.
// Both channels move an item on a clock edge with valid and ready high.
//
// Each request passes through an 8-stage pipeline; throughput is one request
// per cycle while rsp.ready is high. The stage count is set by the three
// reciprocal divisions (by one day, one hour and one minute), each
// multiply followed by a register.
//
// Each stage advances when it is empty or the stage after it advances, so a
// stalled rsp holds the result in the output register while bubbles ahead of
// it fill; req.ready drops only when every stage is full.
// Synchronous reset empties the pipeline; no result is left pending.
`timescale 1ns / 1ps

module day_time_duration_alu #(
  parameter int DAY_BITS = dtd_pkg::DAY_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  dtd_req_if.sink   req,
  dtd_rsp_if.source rsp
);
  import dtd_pkg::*;

  localparam int DW = day_calc_w(DAY_BITS);

  logic [NSTAGE-1:0]       en;
  logic signed [SUM_W-1:0] sum;
  logic signed [DW-1:0]    day;
  logic                    arith;
  logic                    cmp;
  dtd_res_t                res;

  dtd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .en        (en)
  );

  dtd_front #(
    .DAY_BITS (DAY_BITS),
    .DW       (DW)
  ) u_front (
    .clk   (clk),
    .en    (en[FRONT_ST-1:0]),
    .req   (req),
    .sum   (sum),
    .day   (day),
    .arith (arith),
    .cmp   (cmp)
  );

  dtd_back #(
    .DAY_BITS (DAY_BITS),
    .DW       (DW)
  ) u_back (
    .clk   (clk),
    .en    (en[NSTAGE-1:FRONT_ST]),
    .sum   (sum),
    .day   (day),
    .arith (arith),
    .cmp   (cmp),
    .res   (res)
  );

  assign rsp.res_day      = res.res_day;
  assign rsp.res_hour     = res.res_hour;
  assign rsp.res_minute   = res.res_minute;
  assign rsp.res_second   = res.res_second;
  assign rsp.compare_true = res.compare_true;
  assign rsp.day_overflow = res.day_overflow;

  // an empty output stage lets the whole pipeline advance
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("request refused with empty output stage");

  a_time_normalized: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.res_hour <= HOUR_W'(23)) && (rsp.res_minute <= MIN_W'(59))
                  && (rsp.res_second <= SEC_W'(59)))
    else $error("result time not normalized");

  a_compare_clears_time: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.compare_true |-> (rsp.res_day == '0) && !rsp.day_overflow
                                      && (rsp.res_hour == '0))
    else $error("compare result carries time fields");

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the day/time duration alu
`timescale 1ns / 1ps

module tb_top;
  import dtd_pkg::*;

  localparam int DAY_HI   = (1 << (DAY_BITS_DEF - 1)) - 1;
  localparam int DAY_LO   = -DAY_HI - 1;
  localparam int FUNC_TOP = (1 << FUNC_W) - 1;

  typedef struct {
    logic [FUNC_W-1:0]       func;
    logic signed [DAY_W-1:0] a_day;
    logic [HOUR_W-1:0]       a_hour;
    logic [MIN_W-1:0]        a_minute;
    logic [SEC_W-1:0]        a_second;
    logic signed [DAY_W-1:0] b_day;
    logic [HOUR_W-1:0]       b_hour;
    logic [MIN_W-1:0]        b_minute;
    logic [SEC_W-1:0]        b_second;
    logic [DELTA_W-1:0]      seconds_delta;
  } dur_req_t;

  logic clk;
  logic rst;
  bit   stall_on;
  int   mismatches;

  dtd_res_t expected_results[$];
  dtd_res_t seen_result;
  dtd_res_t want_result;

  dtd_req_if req_if ();
  dtd_rsp_if rsp_if ();

  day_time_duration_alu u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint total_seconds(logic signed [DAY_W-1:0] d, logic [HOUR_W-1:0] h,
                                           logic [MIN_W-1:0] m, logic [SEC_W-1:0] s);
    return longint'(d) * SEC_PER_DAY + longint'(h) * SEC_PER_HOUR
         + longint'(m) * SEC_PER_MIN + longint'(s);
  endfunction

  function automatic dtd_res_t predict_duration(dur_req_t r);
    dtd_res_t res;
    longint   ta, tb_s, t, q, rem;
    bit       eq, gt;
    res = '0;
    if (r.func <= FN_SUB_SECS) begin
      ta   = total_seconds(r.a_day, r.a_hour, r.a_minute, r.a_second);
      tb_s = total_seconds(r.b_day, r.b_hour, r.b_minute, r.b_second);
      case (r.func)
        FN_ADD:      t = ta + tb_s;
        FN_SUB:      t = ta - tb_s;
        FN_ADD_SECS: t = ta + longint'(r.seconds_delta);
        default:     t = ta - longint'(r.seconds_delta);
      endcase
      q   = t / SEC_PER_DAY;
      rem = t % SEC_PER_DAY;
      if (rem < 0) begin
        rem += SEC_PER_DAY;
        q   -= 1;
      end
      res.res_day      = q[DAY_W-1:0];
      res.res_hour     = HOUR_W'(rem / SEC_PER_HOUR);
      res.res_minute   = MIN_W'((rem / SEC_PER_MIN) % 60);
      res.res_second   = SEC_W'(rem % SEC_PER_MIN);
      res.day_overflow = (q < DAY_LO) || (q > DAY_HI);
    end else begin
      eq = (r.a_day == r.b_day) && (r.a_hour == r.b_hour) &&
           (r.a_minute == r.b_minute) && (r.a_second == r.b_second);
      if (r.a_day != r.b_day)             gt = r.a_day > r.b_day;
      else if (r.a_hour != r.b_hour)      gt = r.a_hour > r.b_hour;
      else if (r.a_minute != r.b_minute)  gt = r.a_minute > r.b_minute;
      else                                gt = r.a_second > r.b_second;
      case (r.func)
        FN_EQ:   res.compare_true = eq;
        FN_NE:   res.compare_true = !eq;
        FN_GT:   res.compare_true = gt;
        FN_GE:   res.compare_true = gt || eq;
        FN_LT:   res.compare_true = !(gt || eq);
        FN_LE:   res.compare_true = !gt;
        default: res.compare_true = 1'b0;
      endcase
    end
    return res;
  endfunction

  function automatic dur_req_t make_req(func_t f, int ad, int ah, int am, int as_,
                                        int bd, int bh, int bm, int bs, int delta);
    dur_req_t r;
    r.func          = f;
    r.a_day         = DAY_W'(ad);
    r.a_hour        = HOUR_W'(ah);
    r.a_minute      = MIN_W'(am);
    r.a_second      = SEC_W'(as_);
    r.b_day         = DAY_W'(bd);
    r.b_hour        = HOUR_W'(bh);
    r.b_minute      = MIN_W'(bm);
    r.b_second      = SEC_W'(bs);
    r.seconds_delta = DELTA_W'(delta);
    return r;
  endfunction

  function automatic logic signed [DAY_W-1:0] rand_day();
    case ($urandom_range(0, 9))
      0:       return DAY_W'(DAY_HI);
      1:       return DAY_W'(DAY_LO);
      2, 3:    return DAY_W'($urandom_range(0, 6) - 3);
      default: return DAY_W'($urandom());
    endcase
  endfunction

  // mostly normalized, sometimes any value the field width allows
  function automatic int rand_field(int norm_top, int raw_top);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, raw_top)
                                       : $urandom_range(0, norm_top);
  endfunction

  function automatic dur_req_t rand_request();
    dur_req_t r;
    if ($urandom_range(0, 99) < 5) r.func = FUNC_W'($urandom_range(FN_LE + 1, FUNC_TOP));
    else                           r.func = FUNC_W'($urandom_range(FN_ADD, FN_LE));
    r.a_day    = rand_day();
    r.a_hour   = HOUR_W'(rand_field(23, 31));
    r.a_minute = MIN_W'(rand_field(59, 63));
    r.a_second = SEC_W'(rand_field(59, 63));
    r.b_day    = rand_day();
    r.b_hour   = HOUR_W'(rand_field(23, 31));
    r.b_minute = MIN_W'(rand_field(59, 63));
    r.b_second = SEC_W'(rand_field(59, 63));
    case ($urandom_range(0, 9))
      0:          r.seconds_delta = '0;
      1:          r.seconds_delta = DELTA_W'(1);
      2:          r.seconds_delta = '1;
      3, 4, 5:    r.seconds_delta = DELTA_W'($urandom_range(0, 3 * SEC_PER_DAY));
      default:    r.seconds_delta = DELTA_W'($urandom());
    endcase
    // compares mostly see operands that agree down to one field
    if (r.func > FN_SUB_SECS && $urandom_range(0, 99) < 60) begin
      r.b_day    = r.a_day;
      r.b_hour   = r.a_hour;
      r.b_minute = r.a_minute;
      r.b_second = r.a_second;
      case ($urandom_range(0, 4))
        0:       r.b_day    = r.a_day + DAY_W'($urandom_range(0, 1) ? 1 : -1);
        1:       r.b_hour   = HOUR_W'(rand_field(23, 31));
        2:       r.b_minute = MIN_W'(rand_field(59, 63));
        3:       r.b_second = SEC_W'(rand_field(59, 63));
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_request(dur_req_t r);
    while (stall_on && $urandom_range(0, 99) < 32) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid         <= 1'b1;
    req_if.func          <= r.func;
    req_if.a_day         <= r.a_day;
    req_if.a_hour        <= r.a_hour;
    req_if.a_minute      <= r.a_minute;
    req_if.a_second      <= r.a_second;
    req_if.b_day         <= r.b_day;
    req_if.b_hour        <= r.b_hour;
    req_if.b_minute      <= r.b_minute;
    req_if.b_second      <= r.b_second;
    req_if.seconds_delta <= r.seconds_delta;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_results = {expected_results, predict_duration(r)};
  endtask

  task automatic wait_for_results();
    req_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic void note_mismatch(string what, dtd_res_t want, dtd_res_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected day %0d %0d:%0d:%0d cmp %0b ovf %0b,", what,
               $signed(want.res_day), want.res_hour, want.res_minute, want.res_second,
               want.compare_true, want.day_overflow,
               " got day %0d %0d:%0d:%0d cmp %0b ovf %0b", $signed(got.res_day),
               got.res_hour, got.res_minute, got.res_second, got.compare_true,
               got.day_overflow);
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      seen_result.res_day      = rsp_if.res_day;
      seen_result.res_hour     = rsp_if.res_hour;
      seen_result.res_minute   = rsp_if.res_minute;
      seen_result.res_second   = rsp_if.res_second;
      seen_result.compare_true = rsp_if.compare_true;
      seen_result.day_overflow = rsp_if.day_overflow;
      if (expected_results.size() == 0) begin
        note_mismatch("result with no request", '0, seen_result);
      end else begin
        want_result = expected_results.pop_front();
        if (seen_result !== want_result) note_mismatch("result mismatch", want_result,
                                                       seen_result);
      end
    end
  end

  initial begin
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= !stall_on || ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic test_arith_extremes();
    send_request(make_req(FN_ADD, DAY_HI, 23, 59, 59, 0, 0, 0, 1, 0));
    send_request(make_req(FN_ADD, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_request(make_req(FN_SUB, DAY_LO, 0, 0, 0, 0, 0, 0, 1, 0));
    send_request(make_req(FN_SUB, DAY_HI, 23, 59, 59, DAY_LO, 0, 0, 0, 0));
    send_request(make_req(FN_ADD_SECS, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    send_request(make_req(FN_SUB_SECS, DAY_LO, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
    send_request(make_req(FN_ADD_SECS, -1, 23, 59, 59, 0, 0, 0, 0, 1));
    send_request(make_req(FN_SUB_SECS, 0, 0, 0, 0, 0, 0, 0, 0, 1));
  endtask

  task automatic test_compares();
    send_request(make_req(FN_EQ, -5, 12, 30, 30, -5, 12, 30, 30, 0));
    send_request(make_req(FN_NE, DAY_HI, 23, 59, 59, DAY_HI, 23, 59, 59, 0));
    send_request(make_req(FN_GT, 7, 1, 2, 4, 7, 1, 2, 3, 0));
    send_request(make_req(FN_GE, DAY_LO, 0, 0, 0, DAY_LO, 0, 0, 0, 0));
    send_request(make_req(FN_LT, -1, 23, 59, 59, 0, 0, 0, 0, 0));
    send_request(make_req(FN_LE, 3, 4, 6, 0, 3, 4, 5, 59, 0));
  endtask

  task automatic test_raw_fields_and_unused_codes();
    send_request(make_req(FN_ADD, 0, 31, 63, 63, DAY_HI, 31, 63, 63, 0));
    send_request(make_req(FN_GT, 2, 31, 0, 0, 2, 23, 63, 63, 0));
    for (int f = FN_LE + 1; f <= FUNC_TOP; f++) begin
      dur_req_t r;
      r      = rand_request();
      r.func = FUNC_W'(f);
      send_request(r);
    end
  endtask

  task automatic test_random_burst(int count, bit with_stalls);
    stall_on = with_stalls;
    repeat (count) send_request(rand_request());
  endtask

  task automatic test_pause_until_drained();
    stall_on = 1'b1;
    repeat (40) send_request(rand_request());
    wait_for_results();
    repeat (40) send_request(rand_request());
  endtask

  initial begin
    rst                  <= 1'b1;
    stall_on             = 1'b1;
    mismatches           = 0;
    req_if.valid         <= 1'b0;
    req_if.func          <= '0;
    req_if.a_day         <= '0;
    req_if.a_hour        <= '0;
    req_if.a_minute      <= '0;
    req_if.a_second      <= '0;
    req_if.b_day         <= '0;
    req_if.b_hour        <= '0;
    req_if.b_minute      <= '0;
    req_if.b_second      <= '0;
    req_if.seconds_delta <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_arith_extremes();
    test_compares();
    test_raw_fields_and_unused_codes();
    test_random_burst(300, 1'b0);
    test_pause_until_drained();
    test_random_burst(920, 1'b1);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
